FILE: src/lcg_pkg.sv
package lcg_pkg;

   localparam int COORD_BITS      = 16;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int CHAN_BITS       = 8;
   localparam int CHANNELS        = 3;
   localparam int COLOR_BITS      = CHAN_BITS * CHANNELS;

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int RATIO_BITS = RATIO_FRAC_BITS + 1;
   localparam int DIV_STAGES = RATIO_FRAC_BITS + 1;
   localparam int PROD_BITS  = CHAN_BITS + 1 + RATIO_BITS + 1;

   localparam logic [RATIO_BITS-1:0] RATIO_ONE  = {1'b1, {RATIO_FRAC_BITS{1'b0}}};
   localparam logic [RATIO_BITS-1:0] RATIO_ZERO = '0;

   typedef struct packed {
      logic                  pass;
      logic [COLOR_BITS-1:0] begin_color;
      logic [COLOR_BITS-1:0] finish_color;
   } side_type;

   typedef struct packed {
      logic hold;
      logic one;
   } force_type;

endpackage

FILE: src/lcg_ratio.sv
module lcg_ratio import lcg_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DIFF_BITS-1:0]  in_pos,
   input  logic signed [DIFF_BITS-1:0]  in_span,
   input  side_type                     in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [RATIO_BITS-1:0]        out_ratio,
   output side_type                     out_side
);

   logic                       valid_ff [DIV_STAGES];
   logic                       ready    [DIV_STAGES+1];
   logic [DIFF_BITS-1:0]       rem_ff   [DIV_STAGES];
   logic [DIFF_BITS-1:0]       den_ff   [DIV_STAGES];
   logic [RATIO_FRAC_BITS-1:0] quo_ff   [DIV_STAGES];
   force_type                  frc_ff   [DIV_STAGES];
   side_type                   side_ff  [DIV_STAGES];

   logic                 pos_neg;
   logic                 span_neg;
   logic [DIFF_BITS-1:0] apos;
   logic [DIFF_BITS-1:0] aspan;
   logic                 behind;
   logic                 beyond;
   logic                 zero_span;
   force_type            frc_in;

   always_comb begin
      pos_neg   = in_pos[DIFF_BITS-1];
      span_neg  = in_span[DIFF_BITS-1];
      apos      = pos_neg  ? DIFF_BITS'(-in_pos)  : DIFF_BITS'(in_pos);
      aspan     = span_neg ? DIFF_BITS'(-in_span) : DIFF_BITS'(in_span);
      zero_span = (in_span == '0);
      behind    = (in_pos == '0) || (pos_neg != span_neg);
      beyond    = (apos >= aspan);
      frc_in.hold = zero_span || behind || beyond;
      frc_in.one  = zero_span || (!behind && beyond);
   end

   assign ready[DIV_STAGES] = out_ready;
   assign in_ready          = ready[0];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_ready
      assign ready[i] = !valid_ff[i] || ready[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (ready[0] && in_valid) begin
         rem_ff[0]  <= apos;
         den_ff[0]  <= aspan;
         quo_ff[0]  <= '0;
         frc_ff[0]  <= frc_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 1; i < DIV_STAGES; i++) begin : g_div
      logic [DIFF_BITS:0] trial;
      logic               fits;

      assign trial = {rem_ff[i-1], 1'b0};
      assign fits  = (trial >= {1'b0, den_ff[i-1]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         if (ready[i] && valid_ff[i-1]) begin
            rem_ff[i]  <= fits ? DIFF_BITS'(trial - {1'b0, den_ff[i-1]}) : DIFF_BITS'(trial);
            den_ff[i]  <= den_ff[i-1];
            quo_ff[i]  <= {quo_ff[i-1][RATIO_FRAC_BITS-2:0], fits};
            frc_ff[i]  <= frc_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      out_valid = valid_ff[DIV_STAGES-1];
      out_side  = side_ff[DIV_STAGES-1];
      if (frc_ff[DIV_STAGES-1].hold) begin
         out_ratio = frc_ff[DIV_STAGES-1].one ? RATIO_ONE : RATIO_ZERO;
      end else begin
         out_ratio = {1'b0, quo_ff[DIV_STAGES-1]};
      end
   end

endmodule

FILE: src/lcg_lane.sv
module lcg_lane import lcg_pkg::*; (
   input  logic                  clock,
   input  logic                  load,
   input  logic [CHAN_BITS-1:0]  start_chan,
   input  logic [CHAN_BITS-1:0]  end_chan,
   input  logic [RATIO_BITS-1:0] ratio,
   output logic [CHAN_BITS-1:0]  mix
);

   logic signed [CHAN_BITS:0]   diff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic [CHAN_BITS-1:0]        start_ff;
   logic signed [PROD_BITS-1:0] base;
   logic signed [PROD_BITS-1:0] sum;

   assign diff    = $signed({1'b0, end_chan}) - $signed({1'b0, start_chan});
   assign prod_in = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, ratio}));

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= prod_in;
         start_ff <= start_chan;
      end
   end

   assign base = $signed(PROD_BITS'({start_ff, {RATIO_FRAC_BITS{1'b0}}}));
   assign sum  = base + prod_ff;
   assign mix  = sum[RATIO_FRAC_BITS +: CHAN_BITS];

endmodule

FILE: src/line_color_gradient_top.sv
// Blends an RGB888 color for each pixel of a line segment, one request per clock
// while the response is not stalled. The position ratio along the major axis is
// divided out one quotient bit per pipeline stage; a request passes through an
// input register, the divider stages, a lane register and the output register, and
// a new request can enter every cycle while the response is not stalled. Three
// channel lanes blend red, green and blue in parallel, and an output register holds
// the packed color; a pixel already at the end color is passed through unchanged.
// Stages that hold no request fill while the output is stalled.
module line_color_gradient_top import lcg_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_x_major,
   input  logic signed [COORD_BITS-1:0]  req_pixel_x,
   input  logic signed [COORD_BITS-1:0]  req_pixel_y,
   input  logic signed [COORD_BITS-1:0]  req_begin_x,
   input  logic signed [COORD_BITS-1:0]  req_begin_y,
   input  logic signed [COORD_BITS-1:0]  req_finish_x,
   input  logic signed [COORD_BITS-1:0]  req_finish_y,
   input  logic [COLOR_BITS-1:0]         req_pixel_color,
   input  logic [COLOR_BITS-1:0]         req_begin_color,
   input  logic [COLOR_BITS-1:0]         req_finish_color,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COLOR_BITS-1:0]         rsp_blended_color
);

   logic signed [COORD_BITS-1:0] cur;
   logic signed [COORD_BITS-1:0] beg;
   logic signed [COORD_BITS-1:0] fin;
   logic signed [DIFF_BITS-1:0]  pos_in;
   logic signed [DIFF_BITS-1:0]  span_in;
   side_type                     side_in;

   logic                         s1_valid_ff;
   logic signed [DIFF_BITS-1:0]  pos_ff;
   logic signed [DIFF_BITS-1:0]  span_ff;
   side_type                     s1_side_ff;
   logic                         s1_ready;

   logic                         div_in_ready;
   logic                         div_valid;
   logic [RATIO_BITS-1:0]        div_ratio;
   side_type                     div_side;

   logic                         mx_valid_ff;
   side_type                     mx_side_ff;
   logic                         mx_ready;
   logic                         mx_load;
   logic [CHAN_BITS-1:0]         mix [CHANNELS];

   logic                         rsp_valid_ff;
   logic [COLOR_BITS-1:0]        rsp_color_ff;
   logic [COLOR_BITS-1:0]        rsp_color_in;
   logic                         rsp_ready;

   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign mx_ready  = !mx_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || div_in_ready;
   assign req_stall = !s1_ready;
   assign mx_load   = mx_ready && div_valid;

   always_comb begin
      cur = req_x_major ? req_pixel_x  : req_pixel_y;
      beg = req_x_major ? req_begin_x  : req_begin_y;
      fin = req_x_major ? req_finish_x : req_finish_y;
      pos_in  = DIFF_BITS'(cur) - DIFF_BITS'(beg);
      span_in = DIFF_BITS'(fin) - DIFF_BITS'(beg);
      side_in.pass         = (req_pixel_color == req_finish_color);
      side_in.begin_color  = req_begin_color;
      side_in.finish_color = req_finish_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_ready && req_valid) begin
         pos_ff     <= pos_in;
         span_ff    <= span_in;
         s1_side_ff <= side_in;
      end
   end

   lcg_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (div_in_ready),
      .in_pos    (pos_ff),
      .in_span   (span_ff),
      .in_side   (s1_side_ff),
      .out_valid (div_valid),
      .out_ready (mx_ready),
      .out_ratio (div_ratio),
      .out_side  (div_side)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      lcg_lane u_lane (
         .clock      (clock),
         .load       (mx_load),
         .start_chan (div_side.begin_color[c*CHAN_BITS +: CHAN_BITS]),
         .end_chan   (div_side.finish_color[c*CHAN_BITS +: CHAN_BITS]),
         .ratio      (div_ratio),
         .mix        (mix[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mx_valid_ff <= 1'b0;
      end else if (mx_ready) begin
         mx_valid_ff <= div_valid;
      end
      if (mx_load) begin
         mx_side_ff <= div_side;
      end
   end

   always_comb begin
      rsp_color_in = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         rsp_color_in[c*CHAN_BITS +: CHAN_BITS] = mix[c];
      end
      if (mx_side_ff.pass) begin
         rsp_color_in = mx_side_ff.finish_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= mx_valid_ff;
      end
      if (rsp_ready && mx_valid_ff) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blended_color = rsp_color_ff;

endmodule
